/* sv/phr_pkg.sv */
// phr_pkg: shared constants, tint descriptor type and fixed-point helpers
// for the palette HSL recolor core. No dependencies.
`default_nettype none
package phr_pkg;

  localparam int FRAC = 16;             // fraction bits of the Q1.F values
  localparam int LW   = FRAC + 1;       // holds 0..ONE inclusive
  localparam int CW   = $clog2(LW);     // divider step counter
  localparam int DW   = 12;             // divider dividend / remainder
  localparam int DVW  = 11;             // divider divisor
  localparam int NUMW = 17;             // lightness numerator, max 130050

  localparam logic [LW-1:0] ONE   = LW'(1) << FRAC;
  localparam logic [LW-1:0] THIRD = LW'((64'd1 << FRAC) / 64'd3);

  // lightness divide by 130050 through a reciprocal
  localparam logic [NUMW-1:0] LDIV = NUMW'(130050);
  localparam int RK = 24;
  localparam int MW = FRAC + 8;
  localparam logic [63:0] RECIP64 = (64'd1 << (FRAC + RK)) / 64'd130050;
  localparam logic [MW-1:0] RECIP = RECIP64[MW-1:0];

  // configuration register indexes
  localparam logic [1:0] CFG_TINT   = 2'd0;
  localparam logic [1:0] CFG_COUNT  = 2'd1;
  localparam logic [1:0] CFG_FORMAT = 2'd2;

  typedef struct packed {
    logic          gray;       // tint has no chroma
    logic [15:0]   lum_base;   // added to gain * Y
    logic [8:0]    lum_gain;
    logic [LW-1:0] sat;
    logic [LW-1:0] f_r;        // per-channel ramp factor, 0..ONE
    logic [LW-1:0] f_g;
    logic [LW-1:0] f_b;
  } tint_t;

  // channel value = v1 + span * factor; factor ONE gives v2, zero gives v1
  function automatic logic [LW-1:0] hue_factor(input logic [LW-1:0] t);
    logic [FRAC+2:0] te;
    logic [FRAC+2:0] t6;
    logic [FRAC+2:0] one_e;
    te    = (FRAC+3)'(t);
    one_e = (FRAC+3)'(ONE);
    t6    = (te << 2) + (te << 1);
    if (t6 < one_e) return LW'(t6);
    else if ((te << 1) < one_e) return ONE;
    else if ((te << 1) + te < (one_e << 1)) return LW'((one_e << 2) - t6);
    else return '0;
  endfunction

  function automatic logic [7:0] to_byte(input logic [LW-1:0] v);
    logic [LW+7:0] m;
    logic [LW+7:0] sh;
    m  = {v, 8'd0} - (LW+8)'(v);
    sh = m >> FRAC;
    if (sh > (LW+8)'(255)) return 8'd255;
    else return sh[7:0];
  endfunction

endpackage
`default_nettype wire

/* sv/phr_div.sv */
// phr_div: serial restoring divider, one quotient bit per cycle.
// Quotient = floor(dividend * 2^FRAC / divisor). Uses phr_pkg.
`default_nettype none
module phr_div (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [phr_pkg::DW-1:0]  dividend,
  input  wire logic [phr_pkg::DVW-1:0] divisor,
  output logic                         done,
  output logic [phr_pkg::LW-1:0]       quotient
);

  logic                    running;
  logic [phr_pkg::CW-1:0]  cnt;
  logic [phr_pkg::DW-1:0]  rem;
  logic [phr_pkg::DVW-1:0] dvs;
  logic [phr_pkg::DW:0]    cand;
  logic [phr_pkg::DW:0]    diff;
  logic                    ge;

  always_comb begin
    cand = (cnt == '0) ? {1'b0, rem} : {rem, 1'b0};
    ge   = cand >= (phr_pkg::DW+1)'(dvs);
    diff = cand - (phr_pkg::DW+1)'(dvs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= dividend;
        dvs     <= divisor;
      end else if (running) begin
        rem      <= ge ? diff[phr_pkg::DW-1:0] : cand[phr_pkg::DW-1:0];
        quotient <= {quotient[phr_pkg::LW-2:0], ge};
        cnt      <= cnt + 1'b1;
        if (cnt == phr_pkg::CW'(phr_pkg::LW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* sv/phr_cfg.sv */
// phr_cfg: tint analysis. Derives saturation, hue ramp factors and the
// lightness compensation terms from the tint color. Uses phr_pkg, phr_div.
`default_nettype none
module phr_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        tint_wr,
  input  wire logic [23:0] tint,
  output logic             busy,
  output phr_pkg::tint_t   tint_out
);

  typedef enum logic [2:0] {
    C_IDLE, C_LAUNCH_S, C_WAIT_S, C_LAUNCH_H, C_WAIT_H, C_FACT
  } cstate_t;

  cstate_t state;

  logic [7:0]  r, g, b, mx, mn, dl, d;
  logic [8:0]  sum, den;
  logic [10:0] dl6;
  logic signed [11:0] rs, gs, bs, dls, hn_raw, hn;
  logic [phr_pkg::LW-1:0] s_q, h_q, tr, tb;

  logic                    div_start, div_done;
  logic [phr_pkg::DW-1:0]  div_a;
  logic [phr_pkg::DVW-1:0] div_d;
  logic [phr_pkg::LW-1:0]  div_q;

  always_comb begin
    r   = tint[7:0];
    g   = tint[15:8];
    b   = tint[23:16];
    mx  = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn  = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl  = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    d   = (sum > 9'd255) ? 8'(sum - 9'd255) : 8'(9'd255 - sum);
    den = (sum < 9'd255) ? sum : 9'(10'd510 - {1'b0, sum});
    dl6 = (11'(dl) << 2) + (11'(dl) << 1);
    rs  = $signed({4'd0, r});
    gs  = $signed({4'd0, g});
    bs  = $signed({4'd0, b});
    dls = $signed({4'd0, dl});
    if (r == mx) hn_raw = gs - bs;
    else if (g == mx) hn_raw = (dls <<< 1) + bs - rs;
    else hn_raw = (dls <<< 2) + rs - gs;
    hn = (hn_raw < 0) ? hn_raw + (dls <<< 2) + (dls <<< 1) : hn_raw;

    tr = h_q + phr_pkg::THIRD;
    if (tr > phr_pkg::ONE) tr = tr - phr_pkg::ONE;
    tb = (h_q < phr_pkg::THIRD) ? h_q + phr_pkg::ONE - phr_pkg::THIRD
                                : h_q - phr_pkg::THIRD;

    div_start = (state == C_LAUNCH_S) || (state == C_LAUNCH_H);
    div_a     = (state == C_LAUNCH_S) ? phr_pkg::DW'(dl) : hn[phr_pkg::DW-1:0];
    div_d     = (state == C_LAUNCH_S) ? phr_pkg::DVW'(den) : dl6;
    busy      = (state != C_IDLE);
  end

  phr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // reset runs one analysis pass so the descriptor matches a zero tint
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_LAUNCH_S;
    end else if (tint_wr) begin
      state <= C_LAUNCH_S;
    end else begin
      case (state)
        C_IDLE:     state <= C_IDLE;
        C_LAUNCH_S: state <= C_WAIT_S;
        C_WAIT_S: begin
          if (div_done) begin
            s_q   <= div_q;
            state <= C_LAUNCH_H;
          end
        end
        C_LAUNCH_H: state <= C_WAIT_H;
        C_WAIT_H: begin
          if (div_done) begin
            h_q   <= div_q;
            state <= C_FACT;
          end
        end
        C_FACT: begin
          tint_out.gray     <= (dl == 8'd0);
          tint_out.lum_base <= (sum > 9'd255) ? (16'(d) << 8) - 16'(d) : 16'd0;
          tint_out.lum_gain <= 9'(10'd510 - 10'(d));
          tint_out.sat      <= s_q;
          tint_out.f_r      <= phr_pkg::hue_factor(tr);
          tint_out.f_g      <= phr_pkg::hue_factor(h_q);
          tint_out.f_b      <= phr_pkg::hue_factor(tb);
          state             <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/phr_pipe.sv */
// phr_pipe: seven-stage recolor datapath: lightness, HSL to RGB, packing.
// Uses phr_pkg; tint descriptor comes from phr_cfg.
`default_nettype none
module phr_pipe (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [7:0]     entry_index,
  input  wire logic [7:0]     byte_zero,
  input  wire logic [7:0]     byte_one,
  input  wire logic [7:0]     byte_two,
  input  wire logic [7:0]     exchange_count,
  input  wire logic           pixel_format,
  input  wire phr_pkg::tint_t tint,
  output logic                strobe,
  output logic [23:0]         packed_color,
  output logic                was_recolored
);

  localparam int LW = phr_pkg::LW;
  localparam int PW = phr_pkg::NUMW + phr_pkg::MW;
  localparam int RW = phr_pkg::NUMW + phr_pkg::FRAC + 1;

  logic [5:0] vld;
  logic [5:0] hit;
  logic [7:0] b0 [6];
  logic [7:0] b1 [6];
  logic [7:0] b2 [6];

  logic [phr_pkg::NUMW-1:0] num1, num2;
  logic [PW-1:0]   prod2;
  logic [LW-1:0]   l3, l4, l5, l6;
  logic [2*LW-1:0] ls4;
  logic [LW-1:0]   v1_5, span5, v1_6;
  logic [2*LW-1:0] pr6, pg6, pb6;

  logic [LW-1:0]   q0, lsh, v1, ch_r, ch_g, ch_b;
  logic [LW:0]     v2w, l2w;
  logic [RW-1:0]   remw;
  logic [7:0]      o0, o1, o2;

  always_comb begin
    q0   = LW'(prod2 >> phr_pkg::RK);
    remw = ({RW'(num2)} << phr_pkg::FRAC) - RW'(q0) * RW'(phr_pkg::LDIV);

    lsh = LW'(ls4 >> phr_pkg::FRAC);
    if (l4 < (phr_pkg::ONE >> 1)) v2w = (LW+1)'(l4) + (LW+1)'(lsh);
    else v2w = (LW+1)'(l4) + (LW+1)'(tint.sat) - (LW+1)'(lsh);
    l2w = {l4, 1'b0};
    v1  = (l2w >= v2w) ? LW'(l2w - v2w) : '0;

    ch_r = v1_6 + LW'(pr6 >> phr_pkg::FRAC);
    ch_g = v1_6 + LW'(pg6 >> phr_pkg::FRAC);
    ch_b = v1_6 + LW'(pb6 >> phr_pkg::FRAC);
    if (!hit[5]) begin
      o0 = b0[5];
      o1 = b1[5];
      o2 = b2[5];
    end else if (tint.gray) begin
      o0 = phr_pkg::to_byte(l6);
      o1 = o0;
      o2 = o0;
    end else begin
      o0 = phr_pkg::to_byte(ch_r);
      o1 = phr_pkg::to_byte(ch_g);
      o2 = phr_pkg::to_byte(ch_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      strobe <= 1'b0;
    end else begin
      vld    <= {vld[4:0], accept};
      strobe <= vld[5];
    end

    // stage 1: range check, lightness numerator
    hit[0] <= (exchange_count != 8'd0) &&
              ({1'b0, entry_index} >= 9'd256 - {1'b0, exchange_count});
    b0[0]  <= byte_zero;
    b1[0]  <= byte_one;
    b2[0]  <= byte_two;
    num1   <= phr_pkg::NUMW'(tint.lum_base) +
              phr_pkg::NUMW'(tint.lum_gain) * phr_pkg::NUMW'(byte_zero);
    for (int i = 1; i < 6; i++) begin
      hit[i] <= hit[i-1];
      b0[i]  <= b0[i-1];
      b1[i]  <= b1[i-1];
      b2[i]  <= b2[i-1];
    end

    // stage 2: reciprocal product
    prod2 <= PW'(num1) * PW'(phr_pkg::RECIP);
    num2  <= num1;

    // stage 3: quotient is low by at most one
    l3 <= q0 + LW'(remw >= RW'(phr_pkg::LDIV));

    // stage 4: S * L
    ls4 <= (2*LW)'(l3) * (2*LW)'(tint.sat);
    l4  <= l3;

    // stage 5: v1, v2
    v1_5  <= v1;
    span5 <= LW'(v2w) - v1;
    l5    <= l4;

    // stage 6: ramp products
    pr6  <= (2*LW)'(span5) * (2*LW)'(tint.f_r);
    pg6  <= (2*LW)'(span5) * (2*LW)'(tint.f_g);
    pb6  <= (2*LW)'(span5) * (2*LW)'(tint.f_b);
    v1_6 <= v1_5;
    l6   <= l5;

    // stage 7: bytes and packing
    was_recolored <= hit[5];
    if (pixel_format) packed_color <= {12'd0, o0[7:4], o1[7:4], o2[7:4]};
    else packed_color <= {o0, o1, o2};
  end

endmodule
`default_nettype wire

/* sv/palette_hsl_recolor_core.sv */
// Palette HSL recolor core: one palette word in per cycle while busy is low,
// one out per cycle. An accepted word passes 7 register stages to the result
// ports. Throughput: 1 word per cycle through the 7-stage pipeline (S*L and
// ramp muls) while busy is low.
// After reset and after each tint write, busy holds while the serial divider
// derives saturation and hue (two divides of 17 quotient bits each).
// Reset is synchronous; it clears the config registers and reruns tint analysis.
`default_nettype none
module palette_hsl_recolor_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  entry_index,
  input  wire logic [7:0]  byte_zero,
  input  wire logic [7:0]  byte_one,
  input  wire logic [7:0]  byte_two,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  output logic             strobe,
  output logic [23:0]      packed_color,
  output logic             was_recolored
);

  logic [23:0] tint_color;
  logic [7:0]  exchange_count;
  logic        pixel_format;
  logic        cfg_wr, tint_wr, accept;
  phr_pkg::tint_t tint;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign tint_wr   = cfg_wr && (cfg_index == phr_pkg::CFG_TINT);
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      tint_color     <= '0;
      exchange_count <= '0;
      pixel_format   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        phr_pkg::CFG_TINT:   tint_color     <= cfg_data;
        phr_pkg::CFG_COUNT:  exchange_count <= cfg_data[7:0];
        phr_pkg::CFG_FORMAT: pixel_format   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  phr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .tint_wr  (tint_wr),
    .tint     (tint_color),
    .busy     (busy),
    .tint_out (tint)
  );

  phr_pipe u_pipe (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .entry_index    (entry_index),
    .byte_zero      (byte_zero),
    .byte_one       (byte_one),
    .byte_two       (byte_two),
    .exchange_count (exchange_count),
    .pixel_format   (pixel_format),
    .tint           (tint),
    .strobe         (strobe),
    .packed_color   (packed_color),
    .was_recolored  (was_recolored)
  );

endmodule
`default_nettype wire

/* sv/phr_check.sv */
// phr_check: port-level timing checks for palette_hsl_recolor_core,
// bound to the top level. Depends on phr_pkg for the register index.
`default_nettype none
module phr_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready,
  input wire logic [1:0] cfg_index,
  input wire logic       strobe
);

  a_word_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##7 strobe)
    else $error("accepted word did not come out after 7 cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, 7))
    else $error("result strobe without a matching accepted word");

  a_tint_busy: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == phr_pkg::CFG_TINT) |=> busy)
    else $error("tint write did not start analysis");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ($past(rst) ||
      $past(cfg_valid && cfg_ready && cfg_index == phr_pkg::CFG_TINT)))
    else $error("busy rose without tint write or reset");

endmodule

bind palette_hsl_recolor_core phr_check u_phr_check (.*);
`default_nettype wire

/* bench/testbench.sv */
// Testbench for palette_hsl_recolor_core: a directed table, then random words under several
// register settings, all checked against an HSL recolor predictor kept in this file.
// Depends on phr_pkg (register indexes) and the core RTL.
`default_nettype none
module testbench;

  localparam logic [1:0] CFG_SPARE = 2'd3;   // unmapped index, must be ignored
  localparam longint     Q_ONE     = 64'd1 << 16;
  localparam int         STALL_MAX = 4000;

  typedef enum logic [1:0] {ROW_WORD, ROW_CFG} row_kind_t;
  typedef struct {
    row_kind_t   kind;
    logic [7:0]  idx, b0, b1, b2;
    logic [1:0]  reg_sel;
    logic [23:0] reg_val;
    bit          typed;
    logic [23:0] color;
    logic        hit;
  } row_t;
  typedef struct { logic [23:0] color; logic hit; } recolor_t;

  logic clk, rst, start, busy, cfg_valid, cfg_ready, strobe, was_recolored;
  logic [7:0] entry_index, byte_zero, byte_one, byte_two;
  logic [1:0] cfg_index;
  logic [23:0] cfg_data, packed_color;

  logic [23:0] tint_reg;
  logic [7:0] count_reg;
  logic format_reg;
  recolor_t recolor_q[$];
  int errors, stall_cycles;
  bit calm;

  palette_hsl_recolor_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .entry_index(entry_index), .byte_zero(byte_zero), .byte_one(byte_one),
    .byte_two(byte_two), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .strobe(strobe),
    .packed_color(packed_color), .was_recolored(was_recolored)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint ramp_value(longint t, longint v1, longint v2);
    longint span;
    span = v2 - v1;
    if (t < 0) t += Q_ONE;
    if (t > Q_ONE) t -= Q_ONE;
    if (6 * t < Q_ONE) return v1 + ((span * 6 * t) >>> 16);
    if (2 * t < Q_ONE) return v2;
    if (3 * t < 2 * Q_ONE) return v1 + ((span * (4 * Q_ONE - 6 * t)) >>> 16);
    return v1;
  endfunction

  function automatic longint level_to_byte(longint v);
    longint b;
    if (v < 0) v = 0;
    b = (v * 255) >>> 16;
    return b > 255 ? 255 : b;
  endfunction

  function automatic recolor_t predict_recolor(logic [7:0] idx, logic [7:0] b0,
                                               logic [7:0] b1, logic [7:0] b2);
    recolor_t res;
    longint p0, p1, p2, r, g, b, mx, mn, dl, sum, d, num, lq, s, h, v1, v2, third;
    p0 = b0; p1 = b1; p2 = b2;
    res.hit = count_reg != 0 && int'(idx) >= 256 - int'(count_reg);
    if (res.hit) begin
      r = tint_reg[7:0]; g = tint_reg[15:8]; b = tint_reg[23:16];
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      dl = mx - mn;
      sum = mx + mn;
      d = sum > 255 ? sum - 255 : 255 - sum;
      num = (sum > 255) ? 255 * d + (510 - d) * p0 : (510 - d) * p0;
      lq = (num << 16) / 130050;
      if (dl == 0) begin
        p0 = level_to_byte(lq); p1 = p0; p2 = p0;
      end else begin
        s = (dl << 16) / (sum < 255 ? sum : 510 - sum);
        if (r == mx) num = g - b;
        else if (g == mx) num = 2 * dl + b - r;
        else num = 4 * dl + r - g;
        if (num < 0) num += 6 * dl;
        h = (num << 16) / (6 * dl);
        if (2 * lq < Q_ONE) v2 = (lq * (Q_ONE + s)) >>> 16;
        else v2 = lq + s - ((s * lq) >>> 16);
        v1 = 2 * lq - v2;
        if (v1 < 0) v1 = 0;
        third = Q_ONE / 3;
        p0 = level_to_byte(ramp_value(h + third, v1, v2));
        p1 = level_to_byte(ramp_value(h, v1, v2));
        p2 = level_to_byte(ramp_value(h - third, v1, v2));
      end
    end
    if (!format_reg) res.color = {p0[7:0], p1[7:0], p2[7:0]};
    else res.color = 24'((p0 << 4) & 'hf00) | 24'(p1 & 'hf0) | 24'(p2 >> 4);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // result side: strobe cannot be held off
  always @(posedge clk) begin
    recolor_t want;
    if (!rst && strobe) begin
      if (recolor_q.size() == 0) report_mismatch("unexpected word", packed_color, 24'd0);
      else begin
        want = recolor_q.pop_front();
        if (packed_color !== want.color) report_mismatch("packed_color", packed_color, want.color);
        if (was_recolored !== want.hit)
          report_mismatch("was_recolored", 24'(was_recolored), 24'(want.hit));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (recolor_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);   // pipeline depth is 7
  endtask

  task automatic write_reg(logic [1:0] sel, logic [23:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (sel)
      phr_pkg::CFG_TINT:   tint_reg = val;
      phr_pkg::CFG_COUNT:  count_reg = val[7:0];
      phr_pkg::CFG_FORMAT: format_reg = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(logic [7:0] idx, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                           bit typed, logic [23:0] color, logic hit);
    recolor_t pred;
    int gap;
    if (!calm && $urandom_range(99) < 14) begin
      gap = $urandom_range(4, 1);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    entry_index <= idx; byte_zero <= b0; byte_one <= b1; byte_two <= b2;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pred = predict_recolor(idx, b0, b1, b2);
    if (typed && (pred.color !== color || pred.hit !== hit))
      report_mismatch("table row", color, pred.color);
    recolor_q = {recolor_q, pred};
  endtask

  row_t dir_rows[$];

  function automatic row_t wrow(logic [7:0] i, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                bit typed = 0, logic [23:0] col = 0, logic h = 0);
    row_t rw;
    rw.kind = ROW_WORD; rw.idx = i; rw.b0 = a; rw.b1 = b; rw.b2 = c;
    rw.typed = typed; rw.color = col; rw.hit = h; rw.reg_sel = phr_pkg::CFG_TINT;
    rw.reg_val = 0;
    return rw;
  endfunction

  function automatic row_t crow(logic [1:0] sel, logic [23:0] val);
    row_t rw;
    rw = wrow(0, 0, 0, 0);
    rw.kind = ROW_CFG; rw.reg_sel = sel; rw.reg_val = val;
    return rw;
  endfunction

  function automatic void add_row(row_t rw);
    dir_rows = {dir_rows, rw};
  endfunction

  initial begin
    logic [23:0] t;
    int n;
    rst = 1'b1; start = 1'b0; cfg_valid = 1'b0; cfg_index = phr_pkg::CFG_TINT; cfg_data = 0;
    entry_index = 0; byte_zero = 0; byte_one = 0; byte_two = 0;
    tint_reg = 0; count_reg = 0; format_reg = 0;
    errors = 0; calm = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // after reset: pass-through with bytes in order, then in the 12-bit format
    add_row(wrow(0, 8'h00, 8'h00, 8'h00, 1, 24'h000000, 0));
    add_row(wrow(255, 8'hff, 8'hff, 8'hff, 1, 24'hffffff, 0));
    add_row(wrow(128, 8'h12, 8'h34, 8'h56, 1, 24'h123456, 0));
    add_row(crow(phr_pkg::CFG_FORMAT, 24'h000001));
    add_row(wrow(255, 8'hff, 8'hff, 8'hff, 1, 24'h000fff, 0));
    add_row(wrow(7, 8'h12, 8'h34, 8'h56, 1, 24'h000135, 0));
    // full range, black tint: index 0 still untouched
    add_row(crow(phr_pkg::CFG_COUNT, 24'h0000ff));
    add_row(wrow(0, 8'hab, 8'hcd, 8'hef, 1, 24'h000ace, 0));
    add_row(wrow(255, 8'hff, 8'h00, 8'h00, 1, 24'h000777, 1));
    add_row(wrow(1, 8'h80, 8'h11, 8'h22));
    add_row(crow(phr_pkg::CFG_TINT, 24'h0000ff));      // pure red, sum exactly 255
    add_row(wrow(200, 8'h40, 8'h00, 8'h00));
    add_row(wrow(255, 8'hff, 8'h00, 8'h00));
    add_row(crow(phr_pkg::CFG_FORMAT, 24'h000000));
    add_row(wrow(254, 8'h80, 8'h00, 8'h00));
    add_row(crow(phr_pkg::CFG_TINT, 24'h8000ff));      // red max, negative hue
    add_row(wrow(100, 8'hc0, 8'h00, 8'h00));
    add_row(crow(phr_pkg::CFG_TINT, 24'h00ff00));      // green max
    add_row(wrow(101, 8'h20, 8'h00, 8'h00));
    add_row(crow(phr_pkg::CFG_TINT, 24'hffc0c0));      // blue max, light tint
    add_row(wrow(102, 8'h90, 8'h00, 8'h00));
    add_row(wrow(103, 8'h00, 8'h00, 8'h00));
    add_row(crow(phr_pkg::CFG_TINT, 24'h000040));      // dark tint
    add_row(wrow(104, 8'hff, 8'h00, 8'h00));
    add_row(crow(phr_pkg::CFG_TINT, 24'hffffff));      // white gray
    add_row(wrow(105, 8'h33, 8'h00, 8'h00));
    add_row(crow(phr_pkg::CFG_COUNT, 24'hfff701));     // only index 255, high bits masked
    add_row(wrow(254, 8'h33, 8'h44, 8'h55));
    add_row(wrow(255, 8'h33, 8'h44, 8'h55));
    add_row(crow(CFG_SPARE, 24'h5a5a5a));
    add_row(wrow(255, 8'hc3, 8'h3c, 8'h99));

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) write_reg(dir_rows[k].reg_sel, dir_rows[k].reg_val);
      else send_word(dir_rows[k].idx, dir_rows[k].b0, dir_rows[k].b1, dir_rows[k].b2,
                     dir_rows[k].typed, dir_rows[k].color, dir_rows[k].hit);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: t = 24'($urandom_range(24'hffffff));
        1: t = {3{8'($urandom_range(255))}};
        2: t = 24'hffffff;
        default: t = 24'($urandom_range(24'hffffff));
      endcase
      write_reg(phr_pkg::CFG_TINT, t);
      case (ph)
        0: n = 255;
        1: n = 0;
        2: n = 1;
        default: n = $urandom_range(255);
      endcase
      write_reg(phr_pkg::CFG_COUNT, {16'($urandom), 8'(n)});
      write_reg(phr_pkg::CFG_FORMAT, {23'($urandom), 1'(ph % 2)});
      for (int i = 0; i < 55; i++) begin
        calm = (ph == 3);
        if (ph == 5 && i == 27) drain();
        send_word($urandom_range(1) ? 8'($urandom_range(255)) :
                    8'($urandom_range(255, 255 - (count_reg > 0 ? count_reg - 1 : 0))),
                  8'($urandom), 8'($urandom), 8'($urandom), 0, 0, 0);
      end
    end
    calm = 0;
    drain();
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

/* palette_hsl_recolor_core.f */
sv/phr_pkg.sv
sv/phr_div.sv
sv/phr_cfg.sv
sv/phr_pipe.sv
sv/palette_hsl_recolor_core.sv
sv/phr_check.sv
bench/testbench.sv
